>>> rtl/core/dts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dts_pkg;

   localparam int unsigned MAX_RESULTS = 16;
   localparam int unsigned FIRE_CNT_BITS = 5;
   localparam logic [31:0] NONE_DEADLINE = 32'hFFFF_FFFF;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_SCHEDULE = 1'b1;

   typedef enum logic [1:0] {
      STAT_ACCEPTED = 2'd0,
      STAT_REJECTED = 2'd1,
      STAT_FIRED    = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCHED_WR,
      ST_FIRE,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

>>> rtl/core/dts_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module dts_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/deadline_task_scheduler_unit.sv
// Deadline task scheduler.
// The req_ channel carries one item per transfer: op 1 schedules a task whose
// deadline is the current tick count plus req_delay, op 0 advances time by one.
// The rsp_ channel returns results. A schedule item yields exactly one result,
// accepted or rejected when the store is full. A tick item yields one result per
// task that fires, earliest deadline first and ties in insertion order, at most
// sixteen per tick; rsp_last marks the final one, and a tick with nothing due
// yields nothing. Periodic tasks are stored again at their deadline plus period.
// Task data lives in one RAM with a registered read; every item scans it once,
// one entry per cycle, and every firing scans it again. Items are taken one at
// a time; req_ready is high only while the block idles. A finished result
// waits in the output register while rsp_ready is low; the block holds only
// when it has a next result to emit before that one is taken. Reset empties
// the store, clears the tick count and drops any pending result; the block is
// ready in the cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module deadline_task_scheduler_unit #(
   parameter int unsigned CAPACITY = 16,
   parameter int unsigned ID_BITS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_op,
   input  wire logic [7:0]  req_task_id,
   input  wire logic [31:0] req_delay,
   input  wire logic [31:0] req_period,
   input  wire logic        req_spawn,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_fired_id,
   output logic             rsp_fired_spawn,
   output logic [31:0]      rsp_next_deadline,
   output logic             rsp_last
);
   import dts_pkg::*;

   localparam int unsigned IW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned EW = 65 + ID_BITS;

   state_type state_ff, state_in;

   logic [31:0]        now_ff, now_in;
   logic               op_ff, op_in;
   logic [ID_BITS-1:0] id_ff, id_in;
   logic [31:0]        delay_ff, delay_in;
   logic [31:0]        period_ff, period_in;
   logic               spawn_ff, spawn_in;

   logic               valid_ff [CAPACITY];
   logic               valid_in [CAPACITY];
   logic [IW-1:0]      rank_ff [CAPACITY];
   logic [IW-1:0]      rank_in [CAPACITY];
   logic [CW-1:0]      count_ff, count_in;

   logic [CW-1:0]      scan_addr_ff, scan_addr_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [IW-1:0]      rd_idx_ff, rd_idx_in;

   logic               best_found_ff, best_found_in;
   logic [IW-1:0]      best_idx_ff, best_idx_in;
   logic [IW-1:0]      best_rank_ff, best_rank_in;
   logic [31:0]        best_dl_ff, best_dl_in;
   logic [31:0]        best_per_ff, best_per_in;
   logic [ID_BITS-1:0] best_id_ff, best_id_in;
   logic               best_spawn_ff, best_spawn_in;
   logic               free_found_ff, free_found_in;
   logic [IW-1:0]      free_idx_ff, free_idx_in;

   logic [FIRE_CNT_BITS-1:0] nfire_ff, nfire_in;
   logic               pend_ff, pend_in;
   status_type         res_status_ff, res_status_in;
   logic [31:0]        res_next_ff, res_next_in;
   logic [ID_BITS-1:0] res_id_ff, res_id_in;
   logic               res_spawn_ff, res_spawn_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [7:0]         rsp_id_ff, rsp_id_in;
   logic               rsp_spawn_ff, rsp_spawn_in;
   logic [31:0]        rsp_next_ff, rsp_next_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               ram_wr_en;
   logic [IW-1:0]      ram_wr_addr;
   logic [EW-1:0]      ram_wr_data;
   logic               ram_rd_en;
   logic [EW-1:0]      ram_rd_data;

   logic [31:0]        rd_dl;
   logic [31:0]        rd_per;
   logic [ID_BITS-1:0] rd_id;
   logic               rd_spawn;
   logic               req_fire;
   logic               scan_done;
   logic               due;
   logic               due_scan;
   logic               more;
   logic               out_free;
   logic [31:0]        cur_next;
   logic [31:0]        new_dl;
   logic [31:0]        rearm_dl;

   dts_ram #(
      .WIDTH(EW),
      .DEPTH(CAPACITY)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(scan_addr_ff[IW-1:0]),
      .rd_data(ram_rd_data)
   );

   assign {rd_dl, rd_per, rd_id, rd_spawn} = ram_rd_data;

   assign req_fire = req_valid && req_ready;
   assign scan_done = rd_vld_ff && (rd_idx_ff == IW'(CAPACITY - 1));
   assign due = best_found_ff && (best_dl_ff <= now_ff);
   assign due_scan = best_found_in && (best_dl_in <= now_ff);
   assign more = due && (nfire_ff < FIRE_CNT_BITS'(MAX_RESULTS));
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign cur_next = best_found_ff ? best_dl_ff : NONE_DEADLINE;
   assign new_dl = now_ff + delay_ff;
   assign rearm_dl = best_dl_ff + best_per_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               if (op_ff == OP_SCHEDULE) begin
                  state_in = ST_SCHED_WR;
               end else if (pend_ff) begin
                  state_in = ST_EMIT;
               end else if (due_scan) begin
                  state_in = ST_FIRE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SCHED_WR: state_in = ST_EMIT;
         ST_FIRE:     state_in = ST_SCAN;
         ST_EMIT: begin
            if (out_free) begin
               state_in = (op_ff == OP_TICK && more) ? ST_FIRE : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      req_ready = 1'b0;
      ram_rd_en = 1'b0;
      ram_wr_en = 1'b0;
      ram_wr_addr = best_idx_ff;
      ram_wr_data = {rearm_dl, best_per_ff, best_id_ff, best_spawn_ff};
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_SCAN: ram_rd_en = (scan_addr_ff < CW'(CAPACITY));
         ST_SCHED_WR: begin
            ram_wr_en = free_found_ff;
            ram_wr_addr = free_idx_ff;
            ram_wr_data = {new_dl, period_ff, id_ff, spawn_ff};
         end
         ST_FIRE: ram_wr_en = (best_per_ff != 32'd0);
         ST_EMIT: ;
         default: ;
      endcase
   end

   // Datapath.
   always_comb begin
      now_in = now_ff;
      op_in = op_ff;
      id_in = id_ff;
      delay_in = delay_ff;
      period_in = period_ff;
      spawn_in = spawn_ff;
      valid_in = valid_ff;
      rank_in = rank_ff;
      count_in = count_ff;
      scan_addr_in = scan_addr_ff;
      rd_vld_in = 1'b0;
      rd_idx_in = scan_addr_ff[IW-1:0];
      best_found_in = best_found_ff;
      best_idx_in = best_idx_ff;
      best_rank_in = best_rank_ff;
      best_dl_in = best_dl_ff;
      best_per_in = best_per_ff;
      best_id_in = best_id_ff;
      best_spawn_in = best_spawn_ff;
      free_found_in = free_found_ff;
      free_idx_in = free_idx_ff;
      nfire_in = nfire_ff;
      pend_in = pend_ff;
      res_status_in = res_status_ff;
      res_next_in = res_next_ff;
      res_id_in = res_id_ff;
      res_spawn_in = res_spawn_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in = rsp_id_ff;
      rsp_spawn_in = rsp_spawn_ff;
      rsp_next_in = rsp_next_ff;
      rsp_last_in = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            scan_addr_in = '0;
            best_found_in = 1'b0;
            free_found_in = 1'b0;
            nfire_in = '0;
            pend_in = 1'b0;
            if (req_fire) begin
               op_in = req_op;
               id_in = ID_BITS'(req_task_id);
               delay_in = req_delay;
               period_in = req_period;
               spawn_in = req_spawn;
               if (req_op == OP_TICK) begin
                  now_in = now_ff + 32'd1;
               end
            end
         end
         ST_SCAN: begin
            if (scan_addr_ff < CW'(CAPACITY)) begin
               scan_addr_in = scan_addr_ff + CW'(1);
               rd_vld_in = 1'b1;
            end
            if (rd_vld_ff) begin
               if (valid_ff[rd_idx_ff]) begin
                  if (!best_found_ff || rd_dl < best_dl_ff ||
                      (rd_dl == best_dl_ff && rank_ff[rd_idx_ff] < best_rank_ff)) begin
                     best_found_in = 1'b1;
                     best_idx_in = rd_idx_ff;
                     best_rank_in = rank_ff[rd_idx_ff];
                     best_dl_in = rd_dl;
                     best_per_in = rd_per;
                     best_id_in = rd_id;
                     best_spawn_in = rd_spawn;
                  end
               end else if (!free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
            end
         end
         ST_SCHED_WR: begin
            if (free_found_ff) begin
               valid_in[free_idx_ff] = 1'b1;
               rank_in[free_idx_ff] = IW'(count_ff);
               count_in = count_ff + CW'(1);
               res_status_in = STAT_ACCEPTED;
               res_next_in = (new_dl < cur_next) ? new_dl : cur_next;
            end else begin
               res_status_in = STAT_REJECTED;
               res_next_in = cur_next;
            end
         end
         ST_FIRE: begin
            for (int i = 0; i < CAPACITY; i++) begin
               if (valid_ff[i] && rank_ff[i] > best_rank_ff) begin
                  rank_in[i] = rank_ff[i] - IW'(1);
               end
            end
            if (best_per_ff != 32'd0) begin
               rank_in[best_idx_ff] = IW'(count_ff - CW'(1));
            end else begin
               valid_in[best_idx_ff] = 1'b0;
               count_in = count_ff - CW'(1);
            end
            res_id_in = best_id_ff;
            res_spawn_in = best_spawn_ff;
            nfire_in = nfire_ff + FIRE_CNT_BITS'(1);
            pend_in = 1'b1;
            scan_addr_in = '0;
            best_found_in = 1'b0;
            free_found_in = 1'b0;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               pend_in = 1'b0;
               if (op_ff == OP_SCHEDULE) begin
                  rsp_status_in = res_status_ff;
                  rsp_id_in = 8'd0;
                  rsp_spawn_in = 1'b0;
                  rsp_next_in = res_next_ff;
                  rsp_last_in = 1'b1;
               end else begin
                  rsp_status_in = STAT_FIRED;
                  rsp_id_in = 8'(res_id_ff);
                  rsp_spawn_in = res_spawn_ff;
                  rsp_next_in = cur_next;
                  rsp_last_in = !more;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         now_ff <= '0;
         count_ff <= '0;
         rd_vld_ff <= 1'b0;
         pend_ff <= 1'b0;
         nfire_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CAPACITY; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         now_ff <= now_in;
         count_ff <= count_in;
         rd_vld_ff <= rd_vld_in;
         pend_ff <= pend_in;
         nfire_ff <= nfire_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      id_ff <= id_in;
      delay_ff <= delay_in;
      period_ff <= period_in;
      spawn_ff <= spawn_in;
      rank_ff <= rank_in;
      scan_addr_ff <= scan_addr_in;
      rd_idx_ff <= rd_idx_in;
      best_found_ff <= best_found_in;
      best_idx_ff <= best_idx_in;
      best_rank_ff <= best_rank_in;
      best_dl_ff <= best_dl_in;
      best_per_ff <= best_per_in;
      best_id_ff <= best_id_in;
      best_spawn_ff <= best_spawn_in;
      free_found_ff <= free_found_in;
      free_idx_ff <= free_idx_in;
      res_status_ff <= res_status_in;
      res_next_ff <= res_next_in;
      res_id_ff <= res_id_in;
      res_spawn_ff <= res_spawn_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff <= rsp_id_in;
      rsp_spawn_ff <= rsp_spawn_in;
      rsp_next_ff <= rsp_next_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_fired_id = rsp_id_ff;
   assign rsp_fired_spawn = rsp_spawn_ff;
   assign rsp_next_deadline = rsp_next_ff;
   assign rsp_last = rsp_last_ff;

endmodule

`default_nettype wire

>>> rtl/core/dts_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module dts_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_status,
   input wire logic [7:0]  rsp_fired_id,
   input wire logic        rsp_fired_spawn,
   input wire logic [31:0] rsp_next_deadline,
   input wire logic        rsp_last
);
   import dts_pkg::*;

   // A result that waits keeps its status, next deadline and last flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_next_deadline) && $stable(rsp_last))
   else $error("result payload changed while stalled");

   // No result is shown in the cycle after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
   else $error("result valid right after reset");

   // A schedule result is the only result of its item and names no task.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_FIRED |->
         rsp_last && rsp_fired_id == 8'd0 && !rsp_fired_spawn)
   else $error("malformed schedule result");

   // The status code is always a defined one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == STAT_ACCEPTED || rsp_status == STAT_REJECTED ||
         rsp_status == STAT_FIRED)
   else $error("undefined status code");

endmodule

bind deadline_task_scheduler_unit dts_checker u_dts_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_fired_id     (rsp_fired_id),
   .rsp_fired_spawn  (rsp_fired_spawn),
   .rsp_next_deadline(rsp_next_deadline),
   .rsp_last         (rsp_last)
);

`default_nettype wire
